>>> src/ttw_pkg.sv
package ttw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PTR_W  = $clog2(CELLS + 1);

    // Field widths of the stream beats.
    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [COLOR_W-1:0] RESET_FG    = 4'd7;
    localparam logic [COLOR_W-1:0] RESET_BG    = 4'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG = 1'b0,
        CFG_BG = 1'b1
    } t_cfg_idx;

    // Microprogram addresses.
    localparam int STEP_W = 4;
    typedef enum logic [STEP_W-1:0] {
        ST_RST_FILL  = 4'd0,
        ST_IDLE      = 4'd1,
        ST_PUT       = 4'd2,
        ST_PUT_WR    = 4'd3,
        ST_PUT_ADV   = 4'd4,
        ST_NEWLINE   = 4'd5,
        ST_SCR_PRIME = 4'd6,
        ST_SCR_COPY  = 4'd7,
        ST_FILL      = 4'd8,
        ST_EMIT      = 4'd9,
        ST_CLEAR     = 4'd10,
        ST_READ      = 4'd11,
        ST_READ_CAP  = 4'd12
    } t_step;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_JUMP, SEQ_DISPATCH, SEQ_EMIT
    } t_seq_op;

    typedef enum logic [2:0] {
        COND_ALWAYS, COND_NEWLINE, COND_WRAP, COND_NOT_BOTTOM,
        COND_COPY_MORE, COND_FILL_MORE, COND_RD_OUT
    } t_cond;

    typedef enum logic [2:0] {
        WR_NONE, WR_CHAR, WR_COPY, WR_BLANK, WR_RESET
    } t_wr_op;

    typedef enum logic [1:0] {
        RD_NONE, RD_SRC0, RD_SRC1, RD_USER
    } t_rd_op;

    typedef enum logic [1:0] {
        PTR_HOLD, PTR_CLR, PTR_INC
    } t_ptr_op;

    typedef enum logic [1:0] {
        CUR_HOLD, CUR_INC_COL, CUR_NL, CUR_HOME
    } t_cur_op;

    // One control word of the microprogram.
    typedef struct packed {
        t_seq_op seq;
        t_cond   cond;
        t_step   target;
        t_wr_op  wr;
        t_rd_op  rd;
        t_ptr_op ptr;
        t_cur_op cur;
        logic    scr_set;
        logic    cap;
    } t_uword;

    // Sequencer to datapath.
    typedef struct packed {
        t_uword uw;
        logic   accept;
        logic   emit;
    } t_ctl;

    // Datapath flags tested by conditional jumps.
    typedef struct packed {
        logic newline;
        logic wrap;
        logic bottom;
        logic copy_last;
        logic fill_last;
        logic rd_out;
    } t_status;

endpackage

>>> src/ttw_ram.sv
module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> src/ttw_seq.sv
module ttw_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ttw_pkg::t_func   i_func,
    input  ttw_pkg::t_status i_status,
    input  logic             i_out_free,
    output logic             o_ready,
    output ttw_pkg::t_ctl    o_ctl
);

    function automatic ttw_pkg::t_uword uw(
        input ttw_pkg::t_seq_op seq,
        input ttw_pkg::t_cond   cond,
        input ttw_pkg::t_step   target,
        input ttw_pkg::t_wr_op  wr,
        input ttw_pkg::t_rd_op  rd,
        input ttw_pkg::t_ptr_op ptr,
        input ttw_pkg::t_cur_op cur,
        input logic             scr_set,
        input logic             cap
    );
        ttw_pkg::t_uword w;
        w.seq     = seq;
        w.cond    = cond;
        w.target  = target;
        w.wr      = wr;
        w.rd      = rd;
        w.ptr     = ptr;
        w.cur     = cur;
        w.scr_set = scr_set;
        w.cap     = cap;
        return w;
    endfunction

    // The microprogram. A jump is taken when its condition holds, else the
    // next step follows.
    function automatic ttw_pkg::t_uword rom(input ttw_pkg::t_step s);
        ttw_pkg::t_uword w;
        unique case (s)
            ttw_pkg::ST_RST_FILL:  w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_FILL_MORE,
                                         ttw_pkg::ST_RST_FILL, ttw_pkg::WR_RESET,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_INC,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
            ttw_pkg::ST_IDLE:      w = uw(ttw_pkg::SEQ_DISPATCH, ttw_pkg::COND_ALWAYS,
                                         ttw_pkg::ST_IDLE, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
            ttw_pkg::ST_PUT:       w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_NEWLINE,
                                         ttw_pkg::ST_NEWLINE, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
            ttw_pkg::ST_PUT_WR:    w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_WRAP,
                                         ttw_pkg::ST_NEWLINE, ttw_pkg::WR_CHAR,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
            ttw_pkg::ST_PUT_ADV:   w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_ALWAYS,
                                         ttw_pkg::ST_EMIT, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_INC_COL, 1'b0, 1'b0);
            ttw_pkg::ST_NEWLINE:   w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_NOT_BOTTOM,
                                         ttw_pkg::ST_EMIT, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_CLR,
                                         ttw_pkg::CUR_NL, 1'b0, 1'b0);
            ttw_pkg::ST_SCR_PRIME: w = uw(ttw_pkg::SEQ_NEXT, ttw_pkg::COND_ALWAYS,
                                         ttw_pkg::ST_IDLE, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_SRC0, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_HOLD, 1'b1, 1'b0);
            ttw_pkg::ST_SCR_COPY:  w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_COPY_MORE,
                                         ttw_pkg::ST_SCR_COPY, ttw_pkg::WR_COPY,
                                         ttw_pkg::RD_SRC1, ttw_pkg::PTR_INC,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
            ttw_pkg::ST_FILL:      w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_FILL_MORE,
                                         ttw_pkg::ST_FILL, ttw_pkg::WR_BLANK,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_INC,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
            ttw_pkg::ST_EMIT:      w = uw(ttw_pkg::SEQ_EMIT, ttw_pkg::COND_ALWAYS,
                                         ttw_pkg::ST_IDLE, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
            ttw_pkg::ST_CLEAR:     w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_ALWAYS,
                                         ttw_pkg::ST_FILL, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_CLR,
                                         ttw_pkg::CUR_HOME, 1'b0, 1'b0);
            ttw_pkg::ST_READ:      w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_RD_OUT,
                                         ttw_pkg::ST_EMIT, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_USER, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
            ttw_pkg::ST_READ_CAP:  w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_ALWAYS,
                                         ttw_pkg::ST_EMIT, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b1);
            default:               w = uw(ttw_pkg::SEQ_JUMP, ttw_pkg::COND_ALWAYS,
                                         ttw_pkg::ST_IDLE, ttw_pkg::WR_NONE,
                                         ttw_pkg::RD_NONE, ttw_pkg::PTR_HOLD,
                                         ttw_pkg::CUR_HOLD, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

    ttw_pkg::t_step  r_step;
    ttw_pkg::t_step  n_step;
    ttw_pkg::t_step  step_inc;
    ttw_pkg::t_uword word;
    logic            taken;
    logic            accept;

    assign word     = rom(r_step);
    assign step_inc = ttw_pkg::t_step'(r_step + ttw_pkg::STEP_W'(1));
    assign o_ready  = (word.seq == ttw_pkg::SEQ_DISPATCH);
    assign accept   = o_ready & i_valid;

    // Jump condition select.
    always_comb begin
        unique case (word.cond)
            ttw_pkg::COND_ALWAYS:     taken = 1'b1;
            ttw_pkg::COND_NEWLINE:    taken = i_status.newline;
            ttw_pkg::COND_WRAP:       taken = i_status.wrap;
            ttw_pkg::COND_NOT_BOTTOM: taken = !i_status.bottom;
            ttw_pkg::COND_COPY_MORE:  taken = !i_status.copy_last;
            ttw_pkg::COND_FILL_MORE:  taken = !i_status.fill_last;
            ttw_pkg::COND_RD_OUT:     taken = i_status.rd_out;
            default:                  taken = 1'b1;
        endcase
    end

    // Next step: sequential, conditional jump, dispatch on the operation,
    // or wait for the output register.
    always_comb begin
        n_step = r_step;
        unique case (word.seq)
            ttw_pkg::SEQ_NEXT: n_step = step_inc;
            ttw_pkg::SEQ_JUMP: n_step = taken ? word.target : step_inc;
            ttw_pkg::SEQ_DISPATCH: begin
                if (accept) begin
                    unique case (i_func)
                        ttw_pkg::FUNC_PUT:   n_step = ttw_pkg::ST_PUT;
                        ttw_pkg::FUNC_CLEAR: n_step = ttw_pkg::ST_CLEAR;
                        ttw_pkg::FUNC_READ:  n_step = ttw_pkg::ST_READ;
                        ttw_pkg::FUNC_NONE:  n_step = ttw_pkg::ST_EMIT;
                    endcase
                end
            end
            ttw_pkg::SEQ_EMIT: begin
                if (i_out_free) begin
                    n_step = ttw_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Step counter; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ttw_pkg::ST_RST_FILL;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.uw     = word;
    assign o_ctl.accept = accept;
    assign o_ctl.emit   = (word.seq == ttw_pkg::SEQ_EMIT) & i_out_free;

endmodule

>>> src/ttw_dpath.sv
module ttw_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ttw_pkg::t_ctl               i_ctl,
    input  logic [ttw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [ttw_pkg::RROW_W-1:0]  i_read_row,
    input  logic [ttw_pkg::RCOL_W-1:0]  i_read_column,
    input  logic [ttw_pkg::ATTR_W-1:0]  i_attr,
    input  logic                        i_out_ready,
    output ttw_pkg::t_status            o_status,
    output logic                        o_out_free,
    output logic                        o_out_valid,
    output logic [ttw_pkg::CELL_W-1:0]  o_cell_value,
    output logic [ttw_pkg::RROW_W-1:0]  o_cursor_row,
    output logic [ttw_pkg::RCOL_W-1:0]  o_cursor_column,
    output logic                        o_scrolled
);

    localparam int AW = ttw_pkg::ADDR_W;

    logic [ttw_pkg::CHAR_W-1:0] r_char;
    logic [ttw_pkg::RROW_W-1:0] r_rrow;
    logic [ttw_pkg::RCOL_W-1:0] r_rcol;
    logic [ttw_pkg::ROW_W-1:0]  r_row;
    logic [ttw_pkg::COL_W-1:0]  r_col;
    logic [ttw_pkg::PTR_W-1:0]  r_ptr;
    logic                       r_scr;
    logic [ttw_pkg::CELL_W-1:0] r_cell;
    logic                       r_out_valid;

    logic                       we;
    logic [AW-1:0]              waddr;
    logic [ttw_pkg::CELL_W-1:0] wdata;
    logic                       re;
    logic [AW-1:0]              raddr;
    logic [ttw_pkg::CELL_W-1:0] rdata;
    logic [AW-1:0]              cur_addr;
    logic [AW-1:0]              ptr_addr;

    // Flags for the sequencer's conditional jumps.
    assign o_status.newline   = (r_char == ttw_pkg::CHAR_NEWLINE);
    assign o_status.wrap      = (r_col == ttw_pkg::COL_W'(ttw_pkg::COLUMNS - 1));
    assign o_status.bottom    = (r_row == ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1));
    assign o_status.copy_last =
        (r_ptr == ttw_pkg::PTR_W'(ttw_pkg::CELLS - ttw_pkg::COLUMNS - 1));
    assign o_status.fill_last = (r_ptr == ttw_pkg::PTR_W'(ttw_pkg::CELLS - 1));
    assign o_status.rd_out    = (int'(r_rrow) >= ttw_pkg::ROWS) ||
                                (int'(r_rcol) >= ttw_pkg::COLUMNS);

    assign cur_addr = AW'(r_row * ttw_pkg::COLUMNS + r_col);
    assign ptr_addr = r_ptr[AW-1:0];

    // Write port select.
    always_comb begin
        we    = 1'b1;
        waddr = ptr_addr;
        wdata = {ttw_pkg::RESET_ATTR, ttw_pkg::CHAR_SPACE};
        unique case (i_ctl.uw.wr)
            ttw_pkg::WR_NONE:  we = 1'b0;
            ttw_pkg::WR_CHAR: begin
                waddr = cur_addr;
                wdata = {i_attr, r_char};
            end
            ttw_pkg::WR_COPY:  wdata = rdata;
            ttw_pkg::WR_BLANK: wdata = {i_attr, ttw_pkg::CHAR_SPACE};
            ttw_pkg::WR_RESET: wdata = {ttw_pkg::RESET_ATTR, ttw_pkg::CHAR_SPACE};
            default:           we = 1'b0;
        endcase
    end

    // Read port select: scroll source one row down, or the user's cell.
    always_comb begin
        re    = 1'b1;
        raddr = '0;
        unique case (i_ctl.uw.rd)
            ttw_pkg::RD_NONE: re = 1'b0;
            ttw_pkg::RD_SRC0: raddr = AW'(int'(r_ptr) + ttw_pkg::COLUMNS);
            ttw_pkg::RD_SRC1: raddr = AW'(int'(r_ptr) + ttw_pkg::COLUMNS + 1);
            ttw_pkg::RD_USER: raddr = AW'(r_rrow * ttw_pkg::COLUMNS + r_rcol);
        endcase
    end

    ttw_ram #(
        .WIDTH (ttw_pkg::CELL_W),
        .DEPTH (ttw_pkg::CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Item fields are held for the length of the operation.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_char <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_column;
        end
    end

    // Cursor, sweep pointer and per-item result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_ptr <= '0;
            r_scr <= 1'b0;
        end else begin
            unique case (i_ctl.uw.cur)
                ttw_pkg::CUR_HOLD:    ;
                ttw_pkg::CUR_INC_COL: r_col <= ttw_pkg::COL_W'(r_col + 1'b1);
                ttw_pkg::CUR_NL: begin
                    r_col <= '0;
                    if (!o_status.bottom) begin
                        r_row <= ttw_pkg::ROW_W'(r_row + 1'b1);
                    end
                end
                ttw_pkg::CUR_HOME: begin
                    r_row <= '0;
                    r_col <= '0;
                end
            endcase
            unique case (i_ctl.uw.ptr)
                ttw_pkg::PTR_HOLD: ;
                ttw_pkg::PTR_CLR:  r_ptr <= '0;
                ttw_pkg::PTR_INC:  r_ptr <= ttw_pkg::PTR_W'(r_ptr + 1'b1);
                default:           ;
            endcase
            if (i_ctl.accept) begin
                r_scr <= 1'b0;
            end else if (i_ctl.uw.scr_set) begin
                r_scr <= 1'b1;
            end
        end
    end

    // Captured cell value; zero unless a read fetched one.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cell <= '0;
        end else if (i_ctl.uw.cap) begin
            r_cell <= rdata;
        end
    end

    // Output register; the next item can start while it waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            o_cell_value    <= r_cell;
            o_cursor_row    <= ttw_pkg::RROW_W'(r_row);
            o_cursor_column <= ttw_pkg::RCOL_W'(r_col);
            o_scrolled      <= r_scr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_free  = !r_out_valid || i_out_ready;

endmodule

>>> src/text_terminal_writer.sv
// Text terminal with a 25 by 80 screen of 16-bit cells (character in the low
// byte, attribute above it) and a cursor, driven by a small microprogram over
// one single-port-write, registered-read screen RAM. After reset a clearing
// pass writes blanks with attribute 0x07 to all 2000 cells, one per cycle;
// during that pass no beat is accepted, while color writes are taken.
// Every operation returns one result beat. A plain character is written and
// the cursor advanced; a newline moves the cursor to the next line; a read
// fetches and captures the cell (zero when it lies outside the screen); an
// unused operation goes straight to the result. A clear sweeps every cell.
// A line feed from the bottom row scrolls: one cell is copied per cycle
// through the RAM's read port and the bottom row is then blanked. From the
// cycle in which the result enters the output register, the next beat is
// accepted, even while the result is still held.
module text_terminal_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Operation beat.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, from bit 0: char_code[7:0], read_row[4:0], read_column[6:0], zero pad
    input  logic [ttw_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // tuser: func[1:0]
    input  logic [ttw_pkg::FUNC_W-1:0]      s_axis_tuser,
    // Result beat.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, from bit 0: cell_value[15:0], cursor_row[4:0], cursor_column[6:0],
    // scrolled, zero pad
    output logic [ttw_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // Color register writes.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ttw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ttw_pkg::COLOR_W-1:0]     i_cfg_data
);

    logic [ttw_pkg::COLOR_W-1:0] r_fg;
    logic [ttw_pkg::COLOR_W-1:0] r_bg;
    ttw_pkg::t_status            status;
    ttw_pkg::t_ctl               ctl;
    logic                        out_free;
    logic [ttw_pkg::CELL_W-1:0]  cell_value;
    logic [ttw_pkg::RROW_W-1:0]  cursor_row;
    logic [ttw_pkg::RCOL_W-1:0]  cursor_column;
    logic                        scrolled;

    // Color registers accept a write every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= ttw_pkg::RESET_FG;
            r_bg <= ttw_pkg::RESET_BG;
        end else if (i_cfg_valid) begin
            unique case (ttw_pkg::t_cfg_idx'(i_cfg_index))
                ttw_pkg::CFG_FG: r_fg <= i_cfg_data;
                ttw_pkg::CFG_BG: r_bg <= i_cfg_data;
            endcase
        end
    end

    ttw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_func     (ttw_pkg::t_func'(s_axis_tuser)),
        .i_status   (status),
        .i_out_free (out_free),
        .o_ready    (s_axis_tready),
        .o_ctl      (ctl)
    );

    ttw_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_read_row      (s_axis_tdata[12:8]),
        .i_read_column   (s_axis_tdata[19:13]),
        .i_attr          ({r_bg, r_fg}),
        .i_out_ready     (m_axis_tready),
        .o_status        (status),
        .o_out_free      (out_free),
        .o_out_valid     (m_axis_tvalid),
        .o_cell_value    (cell_value),
        .o_cursor_row    (cursor_row),
        .o_cursor_column (cursor_column),
        .o_scrolled      (scrolled)
    );

    assign m_axis_tdata = {3'b000, scrolled, cursor_column, cursor_row, cell_value};

endmodule

>>> tb/text_terminal_writer_tb.sv
module text_terminal_writer_tb;
    import ttw_pkg::*;

    // One operation beat and one result beat, field by field.
    typedef struct packed {
        t_func               func;
        logic [CHAR_W-1:0]   ch;
        logic [RROW_W-1:0]   rrow;
        logic [RCOL_W-1:0]   rcol;
    } term_op_t;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_val;
        logic [RROW_W-1:0]   row;
        logic [RCOL_W-1:0]   col;
        logic                scrolled;
    } term_status_t;

    localparam int RANDOM_PER_PHASE = 125;
    localparam int HOLD_CYCLES      = 500;
    localparam int HOLD_AFTER       = 300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata = '0;
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [COLOR_W-1:0]     i_cfg_data = '0;

    text_terminal_writer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the terminal: screen, cursor and colors.
    logic [CELL_W-1:0]  screen [CELLS];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] fg_nib;
    logic [COLOR_W-1:0] bg_nib;

    term_op_t       ops_pending[$];
    term_status_t   status_due[$];
    int             n_queued = 0;
    int             n_accepted = 0;
    int             n_results = 0;
    int             n_faults = 0;
    bit             idle_on = 1'b1;
    int             hold_left = 0;
    bit             hold_done = 1'b0;

    task automatic report_fault(input string what, input int got, input int want);
        n_faults++;
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Moves the cursor to the start of the next line and scrolls when it
    // runs off the bottom row. Returns 1 if the screen scrolled.
    function automatic bit line_feed();
        logic [CELL_W-1:0] blank;
        int                i;
        blank = {bg_nib, fg_nib, CHAR_SPACE};
        cur_col = 0;
        cur_row++;
        if (cur_row < ROWS) begin
            return 1'b0;
        end
        for (i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        for (i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = blank;
        end
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    // Applies one operation to the shadow terminal and returns its status.
    function automatic term_status_t screen_step(input term_op_t op);
        term_status_t      st;
        logic [ATTR_W-1:0] attr;
        int                i;
        st = '0;
        attr = {bg_nib, fg_nib};
        case (op.func)
            FUNC_PUT: begin
                if (op.ch == CHAR_NEWLINE) begin
                    st.scrolled = line_feed();
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = {attr, op.ch};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        st.scrolled = line_feed();
                    end
                end
            end
            FUNC_CLEAR: begin
                for (i = 0; i < CELLS; i++) begin
                    screen[i] = {attr, CHAR_SPACE};
                end
                cur_row = 0;
                cur_col = 0;
            end
            FUNC_READ: begin
                if (op.rrow < ROWS && op.rcol < COLUMNS) begin
                    st.cell_val = screen[op.rrow * COLUMNS + op.rcol];
                end
            end
            default: begin
            end
        endcase
        st.row = RROW_W'(cur_row);
        st.col = RCOL_W'(cur_col);
        return st;
    endfunction

    function automatic void queue_op(input t_func f, input logic [CHAR_W-1:0] ch,
                                     input logic [RROW_W-1:0] rr,
                                     input logic [RCOL_W-1:0] rc);
        term_op_t op;
        op.func = f;
        op.ch = ch;
        op.rrow = rr;
        op.rcol = rc;
        ops_pending.push_back(op);
        n_queued++;
    endfunction

    // Mostly text with line feeds so the cursor reaches the bottom row and
    // scrolls; reads lean toward the lower rows where the text ends up.
    function automatic void queue_random_op();
        int                 pick;
        t_func              f;
        logic [CHAR_W-1:0]  ch;
        logic [RROW_W-1:0]  rr;
        logic [RCOL_W-1:0]  rc;
        ch = $urandom_range(255);
        rr = $urandom_range(31);
        rc = $urandom_range(127);
        pick = $urandom_range(999);
        if (pick < 5) begin
            f = FUNC_CLEAR;
        end else if (pick < 25) begin
            f = FUNC_NONE;
        end else if (pick < 225) begin
            f = FUNC_READ;
            pick = $urandom_range(99);
            if (pick < 40) begin
                rr = $urandom_range(ROWS - 1, ROWS - 5);
            end else if (pick < 85) begin
                rr = $urandom_range(ROWS - 1);
            end
            if ($urandom_range(99) < 85) begin
                rc = $urandom_range(COLUMNS - 1);
            end
        end else if (pick < 375) begin
            f = FUNC_PUT;
            ch = CHAR_NEWLINE;
        end else begin
            f = FUNC_PUT;
        end
        queue_op(f, ch, rr, rc);
    endfunction

    task automatic write_color(input t_cfg_idx idx, input logic [COLOR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (n_accepted != n_queued || status_due.size() != 0);
    endtask

    // Operation driver: presents queued beats, idling now and then.
    always @(posedge i_clk) begin : drive_ops
        term_op_t op;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (ops_pending.size() > 0 && !(idle_on && $urandom_range(99) < 9)) begin
                op = ops_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= op.func;
                s_axis_tdata <= {{(S_DATA_W - CHAR_W - RROW_W - RCOL_W){1'b0}},
                                 op.rcol, op.rrow, op.ch};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off that backs up
    // the block until it stops taking operation beats.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(99) < 9);
        end
    end

    // Accepted color writes and operation beats update the shadow terminal.
    always @(posedge i_clk) begin : watch_inputs
        term_op_t op;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FG) begin
                    fg_nib = i_cfg_data;
                end else begin
                    bg_nib = i_cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                op.func = t_func'(s_axis_tuser);
                op.ch = s_axis_tdata[CHAR_W-1:0];
                op.rrow = s_axis_tdata[CHAR_W +: RROW_W];
                op.rcol = s_axis_tdata[CHAR_W + RROW_W +: RCOL_W];
                status_due.push_back(screen_step(op));
                n_accepted++;
            end
        end
    end

    // Each result beat is checked against the oldest predicted status.
    always @(posedge i_clk) begin : watch_results
        term_status_t got;
        term_status_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cell_val = m_axis_tdata[CELL_W-1:0];
            got.row = m_axis_tdata[CELL_W +: RROW_W];
            got.col = m_axis_tdata[CELL_W + RROW_W +: RCOL_W];
            got.scrolled = m_axis_tdata[CELL_W + RROW_W + RCOL_W];
            n_results++;
            if (status_due.size() == 0) begin
                report_fault("result beat with none expected", got, 0);
            end else begin
                want = status_due.pop_front();
                if (got.cell_val != want.cell_val) begin
                    report_fault("cell_value", got.cell_val, want.cell_val);
                end
                if (got.row != want.row) begin
                    report_fault("cursor_row", got.row, want.row);
                end
                if (got.col != want.col) begin
                    report_fault("cursor_column", got.col, want.col);
                end
                if (got.scrolled != want.scrolled) begin
                    report_fault("scrolled", got.scrolled, want.scrolled);
                end
            end
        end
    end

    initial begin
        int p;
        for (p = 0; p < CELLS; p++) begin
            screen[p] = {RESET_ATTR, CHAR_SPACE};
        end
        cur_row = 0;
        cur_col = 0;
        fg_nib = RESET_FG;
        bg_nib = RESET_BG;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset colors: reset contents, character
        // extremes, control characters, newline, reads off the screen,
        // the unused operation and a clear.
        queue_op(FUNC_READ, 8'h00, 5'd0, 7'd0);
        queue_op(FUNC_READ, 8'hFF, 5'd24, 7'd79);
        queue_op(FUNC_PUT, 8'h41, 5'd31, 7'd127);
        queue_op(FUNC_PUT, 8'h00, 5'd0, 7'd0);
        queue_op(FUNC_PUT, 8'hFF, 5'd0, 7'd0);
        queue_op(FUNC_PUT, 8'h0D, 5'd0, 7'd0);
        queue_op(FUNC_PUT, 8'h09, 5'd0, 7'd0);
        queue_op(FUNC_PUT, CHAR_NEWLINE, 5'd0, 7'd0);
        queue_op(FUNC_PUT, 8'h7E, 5'd0, 7'd0);
        queue_op(FUNC_READ, 8'h00, 5'd0, 7'd0);
        queue_op(FUNC_READ, 8'h00, 5'd0, 7'd1);
        queue_op(FUNC_READ, 8'h00, 5'd0, 7'd2);
        queue_op(FUNC_READ, 8'h00, 5'd0, 7'd3);
        queue_op(FUNC_READ, 8'h00, 5'd1, 7'd0);
        queue_op(FUNC_READ, 8'h00, 5'd25, 7'd0);
        queue_op(FUNC_READ, 8'h00, 5'd0, 7'd80);
        queue_op(FUNC_READ, 8'hFF, 5'd31, 7'd127);
        queue_op(FUNC_NONE, 8'hFF, 5'd31, 7'd127);
        queue_op(FUNC_NONE, 8'h00, 5'd0, 7'd0);
        queue_op(FUNC_CLEAR, 8'h55, 5'd10, 7'd42);
        queue_op(FUNC_READ, 8'h00, 5'd0, 7'd0);
        queue_op(FUNC_READ, 8'h00, 5'd1, 7'd0);
        queue_op(FUNC_PUT, 8'h80, 5'd0, 7'd0);
        queue_op(FUNC_READ, 8'h00, 5'd0, 7'd0);
        wait_drained();

        // Random phases, each under its own colors; the third runs with
        // no idling on either side.
        for (p = 1; p <= 5; p++) begin
            case (p)
                1: begin
                    write_color(CFG_FG, 4'hF);
                    write_color(CFG_BG, 4'h0);
                end
                2: begin
                    write_color(CFG_FG, 4'h0);
                    write_color(CFG_BG, 4'hF);
                end
                3: begin
                    write_color(CFG_FG, 4'hF);
                    write_color(CFG_BG, 4'hF);
                end
                4: begin
                    write_color(CFG_FG, 4'h0);
                    write_color(CFG_BG, 4'h0);
                end
                default: begin
                    write_color(CFG_BG, COLOR_W'($urandom_range(15)));
                    write_color(CFG_FG, COLOR_W'($urandom_range(15)));
                end
            endcase
            idle_on = (p != 3);
            repeat (RANDOM_PER_PHASE) queue_random_op();
            wait_drained();
            idle_on = 1'b1;
        end

        repeat (20) @(posedge i_clk);
        if (n_faults == 0) begin
            $display("text_terminal_writer: match");
        end else begin
            $display("text_terminal_writer: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(20 * 4_000_000);
        $display("text_terminal_writer: mismatch");
        $finish;
    end

endmodule

>>> sim.f
src/ttw_pkg.sv
src/ttw_ram.sv
src/ttw_seq.sv
src/ttw_dpath.sv
src/text_terminal_writer.sv
tb/text_terminal_writer_tb.sv
